// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the admission block RTL.
// Each macro builds one labeled concurrent assertion, clocked and reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CSAD_ASSERT_IMPL(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// next-cycle implication
`define CSAD_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ===== rtl/csad_pkg.sv =====
// Types and constants of the class slot admission block.
// No dependencies; used by csad_cell and the top level.
package csad_pkg;

	localparam int LIMIT_W   = 8;
	localparam int BW_W      = 20;
	localparam int CLASS_W   = 3;
	localparam int GRANT_W   = 2;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 3;

	localparam logic [CLASS_W-1:0] CLASS_GENERAL = 3'd1;
	localparam logic [CLASS_W-1:0] CLASS_MID     = 3'd2;
	localparam logic [CLASS_W-1:0] CLASS_TOP     = 3'd3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_TOTAL_FULL  = 3'd1,
		ST_BAD_CLASS   = 3'd2,
		ST_NO_SPACE    = 3'd3,
		ST_NONE        = 3'd4,
		ST_CLASS_EMPTY = 3'd5
	} status_t;

	typedef enum logic {
		FUNC_INSTALL = 1'b0,
		FUNC_RELEASE = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL_LIMIT   = 3'd0,
		REG_GENERAL_LIMIT = 3'd1,
		REG_MID_LIMIT     = 3'd2,
		REG_TOP_LIMIT     = 3'd3,
		REG_GENERAL_BW    = 3'd4,
		REG_MID_BW        = 3'd5,
		REG_TOP_BW        = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_SEARCH,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic inc;
		logic dec;
	} cell_ctrl_t;

	typedef struct packed {
		logic full;
		logic nz;
		logic tok;
		logic hit;
	} cell_sts_t;

endpackage

// ===== rtl/csad_cell.sv =====
// One slot counter cell of the admission chain: count, full test and search token.
// Depends on csad_pkg; instantiated once per class, and once for the total, by the top level.
module csad_cell #(
	parameter int COUNT_WIDTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [csad_pkg::LIMIT_W-1:0]  limit,
	input  csad_pkg::cell_ctrl_t          ctrl,
	input  logic                          tok_in,
	output logic                          tok_out,
	output csad_pkg::cell_sts_t           sts
);

	localparam int CMP_W = (COUNT_WIDTH > csad_pkg::LIMIT_W) ? COUNT_WIDTH : csad_pkg::LIMIT_W;

	logic [COUNT_WIDTH-1:0] count_q;
	logic                   tok_q;
	logic                   full;

	assign full = (CMP_W'(count_q) >= CMP_W'(limit)) || (&count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= ctrl.start | tok_in;
			if (ctrl.inc) begin
				count_q <= count_q + COUNT_WIDTH'(1);
			end else if (ctrl.dec) begin
				count_q <= count_q - COUNT_WIDTH'(1);
			end
		end
	end

	// pass the token down while this class is full
	assign tok_out  = tok_q & full;
	assign sts.full = full;
	assign sts.nz   = |count_q;
	assign sts.tok  = tok_q;
	assign sts.hit  = tok_q & ~full;

endmodule

// ===== rtl/class_slot_admission_with_degrade_core.sv =====
// Top level of the class slot admission block with class degrading.
// Depends on csad_pkg, csad_cell and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall, func, class_idx) carries one request per beat:
//   install (func 0) or release (func 1) of a slot in class 1..NUM_CLASSES-1.
//   Output channel (out_valid/out_stall) returns one result beat per request:
//   accepted, granted_class, granted_bw and status.
//   Configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the limits
//   and bandwidths; cfg_ready is always high. Write only while the block is idle.
//   A chain of counter cells, one per class with cell 0 holding the total, keeps
//   the counts; an install sends a token down the chain from the requested class,
//   one cell per cycle, until a cell with room takes it or it reaches cell 0.
//   Steps: the request beat is registered, evaluated in S_EVAL, searched in S_SEARCH on an
//   install past the total and class checks, and its result is loaded in S_FINISH.
//   A new request is taken only after the previous one leaves S_FINISH; the result
//   register lets the next request enter while a result still waits.
//   When the receiver stalls, the result holds and the next finished request
//   waits in its final step until the result register frees.
//   Reset clears all counts, the configuration registers and the result valid.
module class_slot_admission_with_degrade_core #(
	parameter int NUM_CLASSES = 4,
	parameter int COUNT_WIDTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic [csad_pkg::CLASS_W-1:0]    class_idx,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            accepted,
	output logic [csad_pkg::GRANT_W-1:0]    granted_class,
	output logic [csad_pkg::BW_W-1:0]       granted_bw,
	output logic [csad_pkg::STATUS_W-1:0]   status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [csad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csad_pkg::BW_W-1:0]       cfg_data
);

	`include "assert_macros.svh"

	localparam int CW = csad_pkg::CLASS_W;

	csad_pkg::state_t state_q, state_d;

	logic [csad_pkg::LIMIT_W-1:0] total_limit_q, general_limit_q, mid_limit_q, top_limit_q;
	logic [csad_pkg::BW_W-1:0]    general_bw_q, mid_bw_q, top_bw_q;

	csad_pkg::func_t       func_q;
	logic [CW-1:0]         cls_q;
	logic [CW-1:0]         gcls_q;
	logic [csad_pkg::BW_W-1:0] gbw_q;
	csad_pkg::status_t     st_q;
	logic [NUM_CLASSES-1:0] upd_q;

	logic                        out_valid_q;
	logic                        accepted_q;
	logic [csad_pkg::GRANT_W-1:0] granted_class_q;
	logic [csad_pkg::BW_W-1:0]   granted_bw_q;
	csad_pkg::status_t           status_q;

	csad_pkg::cell_ctrl_t ctrl [NUM_CLASSES];
	csad_pkg::cell_sts_t  sts  [NUM_CLASSES];
	logic [csad_pkg::LIMIT_W-1:0] limit [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] tok_down;

	logic [NUM_CLASSES-1:0] sel, full_vec, nz_vec, tok_vec, hit_vec, hit_cls, start_vec;
	logic                   cls_ok, nz_sel, out_free, load_out, do_search;
	logic [CW-1:0]          gcls_enc;
	logic [csad_pkg::BW_W-1:0] bw_enc;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_limit_q   <= '0;
			general_limit_q <= '0;
			mid_limit_q     <= '0;
			top_limit_q     <= '0;
			general_bw_q    <= '0;
			mid_bw_q        <= '0;
			top_bw_q        <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				csad_pkg::REG_TOTAL_LIMIT: begin
					total_limit_q <= cfg_data[csad_pkg::LIMIT_W-1:0];
				end
				csad_pkg::REG_GENERAL_LIMIT: begin
					general_limit_q <= cfg_data[csad_pkg::LIMIT_W-1:0];
				end
				csad_pkg::REG_MID_LIMIT: begin
					mid_limit_q <= cfg_data[csad_pkg::LIMIT_W-1:0];
				end
				csad_pkg::REG_TOP_LIMIT: begin
					top_limit_q <= cfg_data[csad_pkg::LIMIT_W-1:0];
				end
				csad_pkg::REG_GENERAL_BW: begin
					general_bw_q <= cfg_data;
				end
				csad_pkg::REG_MID_BW: begin
					mid_bw_q <= cfg_data;
				end
				csad_pkg::REG_TOP_BW: begin
					top_bw_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// cell chain
	genvar i;
	generate
		for (i = 0; i < NUM_CLASSES; i++) begin : g_cell
			if (i == 0) begin : g_lim
				assign limit[i] = total_limit_q;
			end else if (i == 1) begin : g_lim
				assign limit[i] = general_limit_q;
			end else if (i == 2) begin : g_lim
				assign limit[i] = mid_limit_q;
			end else if (i == 3) begin : g_lim
				assign limit[i] = top_limit_q;
			end else begin : g_lim
				assign limit[i] = '0;
			end

			assign ctrl[i].start = start_vec[i];
			assign ctrl[i].inc   = load_out & (func_q == csad_pkg::FUNC_INSTALL) & upd_q[i];
			assign ctrl[i].dec   = load_out & (func_q == csad_pkg::FUNC_RELEASE) & upd_q[i];

			assign sel[i]      = (cls_q == CW'(i));
			assign full_vec[i] = sts[i].full;
			assign nz_vec[i]   = sts[i].nz;
			assign tok_vec[i]  = sts[i].tok;
			assign hit_vec[i]  = sts[i].hit;

			if (i == 0) begin : g_link
				csad_cell #(
					.COUNT_WIDTH(COUNT_WIDTH)
				) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.limit  (limit[i]),
					.ctrl   (ctrl[i]),
					.tok_in (tok_down[i]),
					.tok_out(),
					.sts    (sts[i])
				);
			end else begin : g_link
				csad_cell #(
					.COUNT_WIDTH(COUNT_WIDTH)
				) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.limit  (limit[i]),
					.ctrl   (ctrl[i]),
					.tok_in (tok_down[i]),
					.tok_out(tok_down[i-1]),
					.sts    (sts[i])
				);
			end
		end
	endgenerate

	assign tok_down[NUM_CLASSES-1] = 1'b0;

	assign cls_ok  = (cls_q != '0) && (int'(cls_q) < NUM_CLASSES);
	assign nz_sel  = |(nz_vec & sel);
	assign hit_cls = hit_vec & ~NUM_CLASSES'(1);

	always_comb begin
		gcls_enc = '0;
		for (int k = 1; k < NUM_CLASSES; k++) begin
			if (hit_cls[k]) begin
				gcls_enc = gcls_enc | CW'(k);
			end
		end
	end

	always_comb begin
		case (gcls_enc)
			csad_pkg::CLASS_GENERAL: bw_enc = general_bw_q;
			csad_pkg::CLASS_MID:     bw_enc = mid_bw_q;
			csad_pkg::CLASS_TOP:     bw_enc = top_bw_q;
			default:                 bw_enc = '0;
		endcase
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign do_search = (func_q == csad_pkg::FUNC_INSTALL) && !full_vec[0] && cls_ok;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			csad_pkg::S_IDLE: begin
				if (in_valid) state_d = csad_pkg::S_EVAL;
			end
			csad_pkg::S_EVAL: begin
				state_d = do_search ? csad_pkg::S_SEARCH : csad_pkg::S_FINISH;
			end
			csad_pkg::S_SEARCH: begin
				if (tok_vec[0] || (|hit_cls)) state_d = csad_pkg::S_FINISH;
			end
			csad_pkg::S_FINISH: begin
				if (out_free) state_d = csad_pkg::S_IDLE;
			end
			default: begin
				state_d = csad_pkg::S_IDLE;
			end
		endcase
	end

	// FSM outputs
	always_comb begin
		in_stall  = 1'b1;
		load_out  = 1'b0;
		start_vec = '0;
		case (state_q)
			csad_pkg::S_IDLE: begin
				in_stall = 1'b0;
			end
			csad_pkg::S_EVAL: begin
				if (do_search) start_vec = sel;
			end
			csad_pkg::S_FINISH: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csad_pkg::S_IDLE;
			upd_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == csad_pkg::S_EVAL) begin
				upd_q <= '0;
				if (func_q == csad_pkg::FUNC_RELEASE && nz_vec[0] && cls_ok && nz_sel) begin
					upd_q <= sel | NUM_CLASSES'(1);
				end
			end else if (state_q == csad_pkg::S_SEARCH && !tok_vec[0] && (|hit_cls)) begin
				upd_q <= hit_cls | NUM_CLASSES'(1);
			end
		end
	end

	// request and result registers
	always_ff @(posedge clk) begin
		if (state_q == csad_pkg::S_IDLE && in_valid) begin
			func_q <= csad_pkg::func_t'(func);
			cls_q  <= class_idx;
		end
		if (state_q == csad_pkg::S_EVAL) begin
			gcls_q <= '0;
			gbw_q  <= '0;
			if (func_q == csad_pkg::FUNC_INSTALL) begin
				if (full_vec[0]) begin
					st_q <= csad_pkg::ST_TOTAL_FULL;
				end else begin
					st_q <= csad_pkg::ST_BAD_CLASS;
				end
			end else begin
				if (!nz_vec[0]) begin
					st_q <= csad_pkg::ST_NONE;
				end else if (!cls_ok) begin
					st_q <= csad_pkg::ST_BAD_CLASS;
				end else if (!nz_sel) begin
					st_q <= csad_pkg::ST_CLASS_EMPTY;
				end else begin
					st_q   <= csad_pkg::ST_OK;
					gcls_q <= cls_q;
				end
			end
		end else if (state_q == csad_pkg::S_SEARCH) begin
			if (tok_vec[0]) begin
				st_q <= csad_pkg::ST_NO_SPACE;
			end else if (|hit_cls) begin
				st_q   <= csad_pkg::ST_OK;
				gcls_q <= gcls_enc;
				gbw_q  <= bw_enc;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			accepted_q      <= (st_q == csad_pkg::ST_OK);
			granted_class_q <= gcls_q[csad_pkg::GRANT_W-1:0];
			granted_bw_q    <= gbw_q;
			status_q        <= st_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign granted_class = granted_class_q;
	assign granted_bw    = granted_bw_q;
	assign status        = status_q;

	`CSAD_ASSERT_IMPL(a_tok_single, clk, arst_n, 1'b1, $onehot0(tok_vec))
	`CSAD_ASSERT_IMPL(a_search_has_tok, clk, arst_n, state_q == csad_pkg::S_SEARCH, $onehot(tok_vec))
	`CSAD_ASSERT_IMPL(a_ok_updates_pair, clk, arst_n,
		state_q == csad_pkg::S_FINISH && st_q == csad_pkg::ST_OK,
		upd_q[0] && $onehot(upd_q & ~NUM_CLASSES'(1)))
	`CSAD_ASSERT_NEXT(a_tok_bottom_fails, clk, arst_n,
		state_q == csad_pkg::S_SEARCH && tok_vec[0],
		state_q == csad_pkg::S_FINISH && st_q == csad_pkg::ST_NO_SPACE)

endmodule
